// ===== hw/rtl/pcs_pkg.sv =====
// shared types, widths and helpers for the per-channel pixel statistics block
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int FULL_SAMPLE_BITS = 16;
    localparam int PIXEL_CHANNELS   = 4;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 17;
    localparam int NBITS_W     = 5;
    localparam int CH_IDX_W    = 2;
    localparam int IN_TDATA_W  = PIXEL_CHANNELS * SAMPLE_W;
    localparam int OUT_PAYLD_W = 3 * SAMPLE_W + COUNT_W + NBITS_W;
    localparam int OUT_TDATA_W = ((OUT_PAYLD_W + 7) / 8) * 8;

    // seen-map entries hold the epoch of the image that marked them, zero is never
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    localparam logic [SAMPLE_W-1:0] NARROW_MASK = 16'h00FF;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [NBITS_W-1:0]  t_nbits;
    typedef logic [CH_IDX_W-1:0] t_ch_idx;

    typedef struct packed {
        t_sample or_mask;
        t_sample low_sample;
        t_sample high_sample;
        t_count  distinct_count;
    } t_chan_stat;

    // smallest b with 2^b >= count, zero for a count of zero or one
    function automatic t_nbits needed_bits(input t_count count);
        t_count m;
        t_nbits b;
        m = count - COUNT_W'(1);
        b = '0;
        if (count > COUNT_W'(1)) begin
            for (int i = 0; i < COUNT_W; i++) begin
                if (m[i]) begin
                    b = NBITS_W'(i + 1);
                end
            end
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/pcs_seen_map.sv =====
// one channel's seen-value memory: epoch tags, one read port and one write port
`timescale 1ns / 1ps

module pcs_seen_map #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/pcs_channel.sv =====
// per-channel accumulators with the seen-map read-modify-write and forwarding
`timescale 1ns / 1ps

module pcs_channel #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [SAMPLE_BITS-1:0]      i_rd_addr,
    input  logic                        i_s1_valid,
    input  logic                        i_s1_last,
    input  logic [SAMPLE_BITS-1:0]      i_s1_sample,
    input  logic [pcs_pkg::EPOCH_W-1:0] i_epoch,
    input  logic                        i_clearing,
    input  logic [SAMPLE_BITS-1:0]      i_clr_addr,
    output pcs_pkg::t_chan_stat         o_stat
);

    import pcs_pkg::*;

    logic [EPOCH_W-1:0]     w_rd_data;
    logic                   w_seen;
    logic                   w_mark;
    logic                   w_wr_en;
    logic [SAMPLE_BITS-1:0] w_wr_addr;
    logic [EPOCH_W-1:0]     w_wr_data;

    logic [SAMPLE_BITS-1:0] r_mask, n_mask;
    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [SAMPLE_BITS:0]   r_count, n_count;
    logic                   r_any;
    logic                   r_fw_valid;
    logic [SAMPLE_BITS-1:0] r_fw_addr;

    pcs_seen_map #(
        .ADDR_W(SAMPLE_BITS),
        .DATA_W(EPOCH_W)
    ) u_seen_map (
        .i_clk    (i_clk),
        .i_rd_en  (i_rd_en),
        .i_rd_addr(i_rd_addr),
        .o_rd_data(w_rd_data),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data)
    );

    // previous item's write lands on the edge this item's read was issued
    assign w_seen = (w_rd_data == i_epoch) || (r_fw_valid && (r_fw_addr == i_s1_sample));
    // full count means every value is already marked
    assign w_mark = i_s1_valid && !w_seen && !r_count[SAMPLE_BITS];

    assign w_wr_en   = i_clearing || w_mark;
    assign w_wr_addr = i_clearing ? i_clr_addr : i_s1_sample;
    assign w_wr_data = i_clearing ? '0 : i_epoch;

    always_comb begin
        n_mask  = r_mask;
        n_min   = r_min;
        n_max   = r_max;
        n_count = r_count;
        if (i_s1_valid) begin
            n_mask = r_mask | i_s1_sample;
            if (!r_any || (i_s1_sample < r_min)) begin
                n_min = i_s1_sample;
            end
            if (!r_any || (i_s1_sample > r_max)) begin
                n_max = i_s1_sample;
            end
            if (w_mark) begin
                n_count = r_count + (SAMPLE_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_count    <= '0;
            r_any      <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= w_mark && !i_s1_last;
            if (i_s1_valid && i_s1_last) begin
                r_mask  <= '0;
                r_min   <= '0;
                r_max   <= '0;
                r_count <= '0;
                r_any   <= 1'b0;
            end else if (i_s1_valid) begin
                r_mask  <= n_mask;
                r_min   <= n_min;
                r_max   <= n_max;
                r_count <= n_count;
                r_any   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= i_s1_sample;
    end

    always_comb begin
        o_stat.or_mask        = SAMPLE_W'(n_mask);
        o_stat.low_sample     = SAMPLE_W'(n_min);
        o_stat.high_sample    = SAMPLE_W'(n_max);
        o_stat.distinct_count = COUNT_W'(n_count);
    end

endmodule

// ===== hw/rtl/pcs_report.sv =====
// report buffer and output register that sends one item per channel
`timescale 1ns / 1ps

module pcs_report #(
    parameter int CHANNELS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  pcs_pkg::t_chan_stat                i_stat [CHANNELS],
    output logic                               o_busy,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // or mask, smallest, largest, distinct count, needed bits, zero fill
    output logic [pcs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // channel index
    output logic [pcs_pkg::CH_IDX_W-1:0]       o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);

    import pcs_pkg::*;

    localparam t_ch_idx LAST_IDX = CH_IDX_W'(CHANNELS - 1);

    t_chan_stat r_buf [CHANNELS];
    logic       r_rep_valid;
    t_ch_idx    r_idx;
    logic       r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    t_ch_idx    r_out_tuser;
    logic       r_out_tlast;

    t_chan_stat w_sel;
    logic       w_send;

    always_comb begin
        w_sel = r_buf[0];
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_idx == CH_IDX_W'(c)) begin
                w_sel = r_buf[c];
            end
        end
    end

    assign w_send = r_rep_valid && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_send) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_rep_valid <= 1'b1;
                r_idx       <= '0;
            end else if (w_send) begin
                r_idx <= r_idx + CH_IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    r_rep_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_stat;
        end
        if (w_send) begin
            r_out_tdata <= OUT_TDATA_W'({needed_bits(w_sel.distinct_count),
                                         w_sel.distinct_count, w_sel.high_sample,
                                         w_sel.low_sample, w_sel.or_mask});
            r_out_tuser <= r_idx;
            r_out_tlast <= (r_idx == LAST_IDX);
        end
    end

    assign o_busy          = r_rep_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;
    assign o_m_axis_tlast  = r_out_tlast;

endmodule

// ===== hw/rtl/per_channel_pixel_statistics.sv =====
// top level of the per-channel pixel statistics block
`timescale 1ns / 1ps

// Per-channel pixel statistics. Each input item is one pixel with up to four
// samples; for every channel the block keeps the OR of all samples, the minimum,
// the maximum and the number of distinct values, and on the pixel flagged tlast
// it sends one report item per channel (tuser carries the channel, tlast marks
// the final channel) and starts fresh for the next image. Pixels are taken at
// one per cycle unless held off as below; the limit is the read-modify-write
// loop through each channel's seen-value memory (read on accept, tag compare and
// write from the item stage, with the previous item's write forwarded). A tlast
// pixel is held off while the previous tlast pixel is in the item stage and while
// its reports are still in the report buffer, which master-side backpressure
// prolongs. The seen memory stores an image epoch per value rather than a bit, so
// images need no clearing; after reset and once every 255 images the epochs wrap
// and a clearing pass over every address runs, during which no pixel is taken.
// The wide_samples register (i_cfg_we / i_cfg_wdata) selects 16-bit samples; at 0
// samples are masked to 8 bits.

module per_channel_pixel_statistics #(
    parameter int SAMPLE_BITS = pcs_pkg::FULL_SAMPLE_BITS,
    parameter int CHANNELS    = pcs_pkg::PIXEL_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // wide_samples register
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    // pixel input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // red_value, green_value, blue_value, alpha_value
    input  logic [pcs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // last_pixel
    input  logic                            i_s_axis_tlast,
    // report output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // or mask, smallest, largest, distinct count, needed bits, zero fill
    output logic [pcs_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // channel_index
    output logic [pcs_pkg::CH_IDX_W-1:0]    o_m_axis_tuser,
    // last_report
    output logic                            o_m_axis_tlast
);

    import pcs_pkg::*;

    logic                   r_wide;

    // item stage: holds the pixel whose seen-map read data is arriving
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [SAMPLE_BITS-1:0] r_s1_sample [CHANNELS];

    // epoch tag and clearing pass
    logic [EPOCH_W-1:0]     r_epoch;
    logic                   r_clearing;
    logic [SAMPLE_BITS-1:0] r_clr_addr;

    logic                   w_accept;
    logic                   w_s1_end;
    logic                   w_wrap;
    logic                   w_rep_busy;
    logic [SAMPLE_BITS-1:0] w_width_mask;
    logic [SAMPLE_BITS-1:0] w_sample [CHANNELS];
    t_chan_stat             w_stat [CHANNELS];

    // narrow mode keeps only the low byte of every sample
    assign w_width_mask = r_wide ? {SAMPLE_BITS{1'b1}} : SAMPLE_BITS'(NARROW_MASK);

    assign w_s1_end = r_s1_valid && r_s1_last;
    assign w_wrap   = w_s1_end && (r_epoch == EPOCH_MAX);

    // a tlast pixel needs the report buffer free when it leaves the item stage;
    // nothing enters while the epochs wrap or the memories are being cleared
    assign o_s_axis_tready = !r_clearing && !w_wrap
                             && !(i_s_axis_tlast && (w_rep_busy || w_s1_end));
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_last  <= w_accept && i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= w_sample;
        end
    end

    // reset starts a clearing pass so every tag reads as never seen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= EPOCH_FIRST;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (w_wrap) begin
                r_epoch    <= EPOCH_FIRST;
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (w_s1_end) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + SAMPLE_BITS'(1);
                if (r_clr_addr == {SAMPLE_BITS{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        assign w_sample[c] = SAMPLE_BITS'(i_s_axis_tdata[c*SAMPLE_W +: SAMPLE_W])
                             & w_width_mask;

        pcs_channel #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_rd_en    (w_accept),
            .i_rd_addr  (w_sample[c]),
            .i_s1_valid (r_s1_valid),
            .i_s1_last  (r_s1_last),
            .i_s1_sample(r_s1_sample[c]),
            .i_epoch    (r_epoch),
            .i_clearing (r_clearing),
            .i_clr_addr (r_clr_addr),
            .o_stat     (w_stat[c])
        );
    end

    // snapshot of the final statistics, including the tlast pixel itself
    pcs_report #(
        .CHANNELS(CHANNELS)
    ) u_report (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_s1_end),
        .i_stat         (w_stat),
        .o_busy         (w_rep_busy),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // the clearing pass never overlaps a pixel in the item stage
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("pixel in flight during clearing pass");

    // a new snapshot never overwrites reports still waiting
    a_snap_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_end |-> !w_rep_busy)
        else $error("report buffer overwritten");

    // the final report item is always the highest channel
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == CH_IDX_W'(CHANNELS - 1)))
        else $error("final report on wrong channel");

    // tag zero stays reserved for cleared entries
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch reached the cleared tag");

endmodule
